FILE: hdl/padded_strided_2d_correlation_assert.svh
// Assertion macros shared by the padded strided 2-D correlation RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PADDED_STRIDED_2D_CORRELATION_ASSERT_SVH
`define PADDED_STRIDED_2D_CORRELATION_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PSC_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication, checked outside reset.
`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hdl/psc_pkg.sv
// Shared types and constants of the padded strided 2-D correlation block.
// No dependencies; imported by every module of the block except psc_ram.
package psc_pkg;

    localparam int MAX_IN_ROWS = 32;
    localparam int MAX_IN_COLS = 32;
    localparam int MAX_KERNEL  = 5;

    localparam int IMG_DEPTH = MAX_IN_ROWS * MAX_IN_COLS;
    localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int KER_AW    = $clog2(KER_DEPTH);

    localparam int IDX_W    = 5;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int SUM_W    = 40;
    localparam int BASE_W   = 9;   // row * stride plus kernel offset

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE_INPUT  = 2'd0,
        OP_WRITE_KERNEL = 2'd1,
        OP_COMPUTE      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_BAD_CONFIG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_INPUT_ROWS  = 3'd0,
        REG_INPUT_COLS  = 3'd1,
        REG_KERNEL_ROWS = 3'd2,
        REG_KERNEL_COLS = 3'd3,
        REG_PAD_AMOUNT  = 3'd4,
        REG_STRIDE_STEP = 3'd5,
        REG_FLIP_MODE   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [5:0] in_rows;
        logic [5:0] in_cols;
        logic [2:0] k_rows;
        logic [2:0] k_cols;
        logic [2:0] pad;
        logic [3:0] stride;
        logic       flip;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_WR_IMAGE  = 2'd0,
        CMD_WR_KERNEL = 2'd1,
        CMD_COMPUTE   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [SAMPLE_W-1:0] value;
        status_t             status;
    } cmd_t;

endpackage

FILE: hdl/padded_strided_2d_correlation.sv
// Top level of the padded strided 2-D correlation engine.
// Depends on psc_pkg, psc_front, psc_queue and psc_back.
//
// Usage:
//  - Requests enter on start when busy is low. operation 0 writes one input
//    sample, 1 writes one kernel coefficient, 2 asks for one output element.
//    Writes beyond the store and the unused code give no result.
//  - Requests pass through a 4-entry queue; busy is high while it is full.
//  - Each compute request gives one result, shown for exactly one cycle with
//    result_valid high. The receiver cannot stall; results are never held.
//  - A write takes effect in the cycle after it leaves the queue.
//  - A flagged request (status 1 or 2) gives its result in the cycle after the
//    request reaches the back end; a good one walks its kernel_rows*kernel_cols
//    taps, one tap per cycle through the single shared multiply-accumulate unit,
//    and registers its result once the last product has passed the store read
//    and product registers. The back end takes no queued request while it runs.
//  - Configuration writes use cfg_valid/cfg_ready (always ready); the user must
//    make them only while the block is idle, which the block does not enforce.
//  - Reset sets the registers to 32, 32, 3, 3, 0, 1, 0 and empties the queue;
//    the stores keep no reset and must be written before they are read.
module padded_strided_2d_correlation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        operation,
    input  logic [psc_pkg::IDX_W-1:0]         row_index,
    input  logic [psc_pkg::IDX_W-1:0]         col_index,
    input  logic signed [psc_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [5:0]                        cfg_data,
    output logic                              result_valid,
    output logic signed [psc_pkg::SUM_W-1:0]  sum_value,
    output logic [1:0]                        status,
    output logic [psc_pkg::IDX_W-1:0]         out_row,
    output logic [psc_pkg::IDX_W-1:0]         out_col
);
    import psc_pkg::*;

    cfg_t cfg;         // live configuration; the user must keep it stable while requests are in flight (not enforced)
    cmd_t push_cmd;    // classified request into the queue
    cmd_t head;        // oldest queued request
    logic push, pop, q_empty, q_full;

    // front: register file, intake, status classification
    psc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .row_index    (row_index),
        .col_index    (col_index),
        .sample_value (sample_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decoupling queue: keeps request order, so writes and computes never pass
    psc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: stores, tap walk, multiply-accumulate and result register
    psc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .sum_value    (sum_value),
        .status       (status),
        .out_row      (out_row),
        .out_col      (out_col)
    );

endmodule

FILE: hdl/psc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/psc_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on psc_pkg.
module psc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output psc_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import psc_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

FILE: hdl/psc_front.sv
// Front end: configuration registers, request intake and classification.
// Depends on psc_pkg; feeds psc_queue.
module psc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [psc_pkg::IDX_W-1:0]     row_index,
    input  logic [psc_pkg::IDX_W-1:0]     col_index,
    input  logic signed [psc_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [5:0]                    cfg_data,
    output psc_pkg::cfg_t                 cfg,
    input  logic                          q_full,
    output logic                          push,
    output psc_pkg::cmd_t                 push_cmd
);
    import psc_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        accept;
    logic        cfg_bad;
    logic        range_bad;
    logic [6:0]  pad_rows, pad_cols;
    logic [BASE_W-1:0] reach_r, reach_c;
    logic [BASE_W-1:0] row_w, col_w, stride_w;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_INPUT_ROWS:  cfg_next.in_rows = cfg_data;
                REG_INPUT_COLS:  cfg_next.in_cols = cfg_data;
                REG_KERNEL_ROWS: cfg_next.k_rows  = cfg_data[2:0];
                REG_KERNEL_COLS: cfg_next.k_cols  = cfg_data[2:0];
                REG_PAD_AMOUNT:  cfg_next.pad     = cfg_data[2:0];
                REG_STRIDE_STEP: cfg_next.stride  = cfg_data[3:0];
                REG_FLIP_MODE:   cfg_next.flip    = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_rows <= 6'd32;
            cfg_reg.in_cols <= 6'd32;
            cfg_reg.k_rows  <= 3'd3;
            cfg_reg.k_cols  <= 3'd3;
            cfg_reg.pad     <= 3'd0;
            cfg_reg.stride  <= 4'd1;
            cfg_reg.flip    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // padded extent and far edge of the requested window
    // (row < out_rows  <=>  row*stride + k_rows <= padded rows)
    assign pad_rows = 7'(cfg_reg.in_rows) + 7'({cfg_reg.pad, 1'b0});
    assign pad_cols = 7'(cfg_reg.in_cols) + 7'({cfg_reg.pad, 1'b0});
    assign row_w    = BASE_W'(row_index);
    assign col_w    = BASE_W'(col_index);
    assign stride_w = BASE_W'(cfg_reg.stride);
    assign reach_r  = row_w * stride_w + BASE_W'(cfg_reg.k_rows);
    assign reach_c  = col_w * stride_w + BASE_W'(cfg_reg.k_cols);

    assign cfg_bad = (cfg_reg.in_rows == '0) || (32'(cfg_reg.in_rows) > MAX_IN_ROWS) ||
                     (cfg_reg.in_cols == '0) || (32'(cfg_reg.in_cols) > MAX_IN_COLS) ||
                     (cfg_reg.k_rows == '0)  || (32'(cfg_reg.k_rows) > MAX_KERNEL)   ||
                     (cfg_reg.k_cols == '0)  || (32'(cfg_reg.k_cols) > MAX_KERNEL)   ||
                     (cfg_reg.stride == '0)  ||
                     (7'(cfg_reg.k_rows) > pad_rows) || (7'(cfg_reg.k_cols) > pad_cols);

    assign range_bad = (reach_r > BASE_W'(pad_rows)) || (reach_c > BASE_W'(pad_cols));

    assign busy   = q_full;
    assign accept = start && !q_full;

    always_comb
    begin
        push_cmd.row    = row_index;
        push_cmd.col    = col_index;
        push_cmd.value  = sample_value;
        push_cmd.status = cfg_bad ? ST_BAD_CONFIG : (range_bad ? ST_RANGE : ST_OK);
        push_cmd.kind   = CMD_COMPUTE;
        push            = 1'b0;
        unique case (op_t'(operation))
            OP_WRITE_INPUT:
            begin
                push_cmd.kind = CMD_WR_IMAGE;
                push = accept && (32'(row_index) < MAX_IN_ROWS) &&
                       (32'(col_index) < MAX_IN_COLS);
            end
            OP_WRITE_KERNEL:
            begin
                push_cmd.kind = CMD_WR_KERNEL;
                push = accept && (32'(row_index) < MAX_KERNEL) &&
                       (32'(col_index) < MAX_KERNEL);
            end
            OP_COMPUTE:
            begin
                push_cmd.kind = CMD_COMPUTE;
                push = accept;
            end
            default:
            begin
                push = 1'b0;   // unused code: dropped
            end
        endcase
    end

endmodule

FILE: hdl/psc_back.sv
// Back end: image and kernel stores, tap sequencer, shared multiply-accumulate.
// Depends on psc_pkg, psc_ram and the assertion macro header.
`include "padded_strided_2d_correlation_assert.svh"
module psc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psc_pkg::cfg_t                 cfg,
    input  psc_pkg::cmd_t                 head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          result_valid,
    output logic signed [psc_pkg::SUM_W-1:0] sum_value,
    output logic [1:0]                    status,
    output logic [psc_pkg::IDX_W-1:0]     out_row,
    output logic [psc_pkg::IDX_W-1:0]     out_col
);
    import psc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        i_reg, i_next, j_reg, j_next;
    logic [BASE_W-1:0] base_r_reg, base_r_next, base_c_reg, base_c_next;
    logic [IDX_W-1:0]  req_row_reg, req_row_next, req_col_reg, req_col_next;
    logic              ok1_reg, ok1_next, last1_reg, last1_next;
    logic              ok2_reg, last2_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next, acc_sum, addend;
    logic              res_valid_reg, res_valid_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  out_row_reg, out_row_next, out_col_reg, out_col_next;

    logic              img_we, ker_we;
    logic [IMG_AW-1:0] img_waddr, img_raddr;
    logic [KER_AW-1:0] ker_waddr, ker_raddr;
    logic [SAMPLE_W-1:0] img_rdata, ker_rdata;

    logic [BASE_W-1:0] yr, xc, ry, cx;
    logic [2:0]        ki, kj;
    logic              tap_ok, last_tap, issue;

    // store writes come straight from the queue head
    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign img_we    = pop && (head.kind == CMD_WR_IMAGE);
    assign ker_we    = pop && (head.kind == CMD_WR_KERNEL);
    assign img_waddr = IMG_AW'(32'(head.row) * MAX_IN_COLS + 32'(head.col));
    assign ker_waddr = KER_AW'(32'(head.row) * MAX_KERNEL + 32'(head.col));

    // tap address generation
    assign issue    = (state_reg == S_RUN);
    assign yr       = base_r_reg + BASE_W'(i_reg);
    assign xc       = base_c_reg + BASE_W'(j_reg);
    assign ry       = yr - BASE_W'(cfg.pad);
    assign cx       = xc - BASE_W'(cfg.pad);
    assign tap_ok   = (yr >= BASE_W'(cfg.pad)) && (ry < BASE_W'(cfg.in_rows)) &&
                      (xc >= BASE_W'(cfg.pad)) && (cx < BASE_W'(cfg.in_cols));
    assign ki       = cfg.flip ? (cfg.k_rows - 3'd1 - i_reg) : i_reg;
    assign kj       = cfg.flip ? (cfg.k_cols - 3'd1 - j_reg) : j_reg;
    assign img_raddr = IMG_AW'(32'(ry) * MAX_IN_COLS + 32'(cx));
    assign ker_raddr = KER_AW'(32'(ki) * MAX_KERNEL + 32'(kj));
    assign last_tap = (i_reg == cfg.k_rows - 3'd1) && (j_reg == cfg.k_cols - 3'd1);

    psc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (IMG_DEPTH)
    ) u_image_store (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (head.value),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    psc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (KER_DEPTH)
    ) u_kernel_store (
        .clk   (clk),
        .we    (ker_we),
        .waddr (ker_waddr),
        .wdata (head.value),
        .raddr (ker_raddr),
        .rdata (ker_rdata)
    );

    assign prod_next = $signed(img_rdata) * $signed(ker_rdata);
    assign addend    = ok2_reg ? {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg} : '0;
    assign acc_sum   = acc_reg + addend;
    assign ok1_next   = issue && tap_ok;
    assign last1_next = issue && last_tap;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        base_r_next    = base_r_reg;
        base_c_next    = base_c_reg;
        req_row_next   = req_row_reg;
        req_col_next   = req_col_reg;
        acc_next       = acc_sum;
        res_valid_next = 1'b0;
        sum_next       = sum_reg;
        status_next    = status_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && (head.kind == CMD_COMPUTE))
                begin
                    if (head.status != ST_OK)
                    begin
                        res_valid_next = 1'b1;
                        sum_next       = '0;
                        status_next    = head.status;
                        out_row_next   = head.row;
                        out_col_next   = head.col;
                    end
                    else
                    begin
                        base_r_next  = BASE_W'(head.row) * BASE_W'(cfg.stride);
                        base_c_next  = BASE_W'(head.col) * BASE_W'(cfg.stride);
                        req_row_next = head.row;
                        req_col_next = head.col;
                        i_next       = '0;
                        j_next       = '0;
                        acc_next     = '0;
                        state_next   = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                end
                else if (j_reg == cfg.k_cols - 3'd1)
                begin
                    j_next = '0;
                    i_next = i_reg + 3'd1;
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                end
            end
            S_DRAIN:
            begin
                if (last2_reg)
                begin
                    res_valid_next = 1'b1;
                    sum_next       = acc_sum;
                    status_next    = ST_OK;
                    out_row_next   = req_row_reg;
                    out_col_next   = req_col_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            ok1_reg       <= 1'b0;
            last1_reg     <= 1'b0;
            ok2_reg       <= 1'b0;
            last2_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ok1_reg       <= ok1_next;
            last1_reg     <= last1_next;
            ok2_reg       <= ok1_reg;
            last2_reg     <= last1_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_r_reg  <= base_r_next;
        base_c_reg  <= base_c_next;
        req_row_reg <= req_row_next;
        req_col_reg <= req_col_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        status_reg  <= status_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
    end

    assign result_valid = res_valid_reg;
    assign sum_value    = sum_reg;
    assign status       = status_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;

    `PSC_ASSERT_IMPLIES(a_result_only_idle, clk, rst_n, res_valid_reg, state_reg == S_IDLE)
    `PSC_ASSERT_IMPLIES(a_last_tap_in_drain, clk, rst_n, last2_reg, state_reg == S_DRAIN)
    `PSC_ASSERT_IMPLIES(a_tap_in_kernel, clk, rst_n, state_reg == S_RUN, (i_reg < cfg.k_rows) && (j_reg < cfg.k_cols))

endmodule
